// ===== hw/rtl/scd_pkg.sv =====
`timescale 1ns / 1ps

package scd_pkg;

   localparam int RING_DEPTH     = 4096;
   localparam int RING_BITS      = $clog2(RING_DEPTH);
   localparam int SINE_ROM_DEPTH = 1024;
   localparam int SINE_BITS      = $clog2(SINE_ROM_DEPTH);
   localparam int QTR_BITS       = SINE_BITS - 2;
   localparam int QTR_ENTRIES    = SINE_ROM_DEPTH / 4 + 1;

   localparam int SAMPLE_BITS = 16;
   localparam int DATA_BITS   = 2 * SAMPLE_BITS;
   localparam int FRAC_BITS   = 8;
   localparam int POS_BITS    = RING_BITS + FRAC_BITS;
   localparam int DLY_BITS    = (POS_BITS + 1 > 23) ? POS_BITS + 1 : 23;

   localparam int CENTER_BITS = 20;
   localparam int DEPTH_BITS  = 20;
   localparam int PHASE_BITS  = 32;
   localparam int MIX_BITS    = 16;

   localparam logic [POS_BITS-1:0] DELAY_MAX = POS_BITS'((RING_DEPTH - 1) * 256);
   localparam logic [MIX_BITS-1:0] MIX_FULL  = 16'd32768;
   localparam logic [7:0]          INTERP_HALF = 8'h80;
   localparam int                  MIX_SHIFT = 15;

   localparam int MAC_A_BITS   = 21;
   localparam int MAC_B_BITS   = 17;
   localparam int MAC_P_BITS   = MAC_A_BITS + MAC_B_BITS;
   localparam int MAC_ACC_BITS = 40;

   localparam logic signed [MAC_ACC_BITS-1:0] MIX_ROUND = MAC_ACC_BITS'(16384);

   localparam logic [CENTER_BITS-1:0] CENTER_RESET = 20'd221184;
   localparam logic [DEPTH_BITS-1:0]  DEPTH_RESET  = 20'd73728;
   localparam logic [PHASE_BITS-1:0]  STEP_RESET   = 32'd31317;
   localparam logic [PHASE_BITS-1:0]  OFFSET_RESET = 32'd1162059236;
   localparam logic [MIX_BITS-1:0]    MIX_RESET    = 16'd0;

   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER_DELAY = 3'd0,
      CSR_DEPTH_DELAY  = 3'd1,
      CSR_LFO_STEP     = 3'd2,
      CSR_RIGHT_OFFSET = 3'd3,
      CSR_MIX_AMOUNT   = 3'd4
   } csr_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic                           issue;
      logic                           load;
      logic signed [MAC_ACC_BITS-1:0] bias;
      logic signed [MAC_A_BITS-1:0]   op_a;
      logic signed [MAC_B_BITS-1:0]   op_b;
   } mac_op_type;

   typedef struct packed {
      logic                 we;
      logic                 re;
      logic [RING_BITS-1:0] addr;
      logic [DATA_BITS-1:0] wdata;
   } ring_req_type;

   localparam longint C1_Q28 = 64'sd421657428;
   localparam longint C3_Q28 = 64'sd173399671;
   localparam longint C5_Q28 = 64'sd21392319;
   localparam longint C7_Q28 = 64'sd1256761;
   localparam longint C9_Q28 = 64'sd43068;

   typedef logic [SAMPLE_BITS-1:0] sine_table_type [QTR_ENTRIES];

   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      longint x;
      longint x2;
      longint t;
      longint s;
      for (int m = 0; m < QTR_ENTRIES; m++) begin
         x  = longint'(m) <<< (18 - SINE_BITS);
         x2 = (x * x) >>> 16;
         t  = C9_Q28;
         t  = C7_Q28 - ((t * x2) >>> 16);
         t  = C5_Q28 - ((t * x2) >>> 16);
         t  = C3_Q28 - ((t * x2) >>> 16);
         t  = C1_Q28 - ((t * x2) >>> 16);
         s  = (t * x) >>> 16;
         s  = (s * 32767 + (longint'(1) <<< 27)) >>> 28;
         if (s > 32767) begin
            s = 32767;
         end
         tbl[m] = s[SAMPLE_BITS-1:0];
      end
      return tbl;
   endfunction

endpackage

// ===== hw/rtl/stereo_chorus_delay_unit.sv =====
`timescale 1ns / 1ps

// channel   direction  beat contents
// req_      in         tdata[15:0] left_sample, tdata[31:16] right_sample
// rsp_      out        tdata[15:0] left_out, tdata[31:16] right_out
// csr_      in         csr_index register number, csr_data value (csr_ready always high)
//
// An input beat occupies the block until its result is loaded into the output register
// and req_tready returns, so a new beat is not taken before the last one is through.
// The work is done by one two-stage multiply-accumulate unit walked through four products
// per voice.
// Reset leaves all delay-line taps reading as zero without a clearing pass.
// A stalled rsp_ holds its beat; the block may take the next req_ beat meanwhile
// and waits before loading its own result until the output register is free.

module stereo_chorus_delay_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [scd_pkg::DATA_BITS-1:0]         req_tdata,  // left_sample, right_sample
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [scd_pkg::DATA_BITS-1:0]         rsp_tdata,  // left_out, right_out
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [scd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [scd_pkg::PHASE_BITS-1:0]        csr_data
);
   import scd_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WRITE,
      S_SINE,
      S_DMUL,
      S_DWAIT,
      S_DPOS,
      S_RD0,
      S_RD1,
      S_INT,
      S_IWAIT,
      S_MIX0,
      S_MIX1,
      S_MWAIT1,
      S_MWAIT2,
      S_DONE
   } state_type;

   logic [CENTER_BITS-1:0] center_ff;
   logic [DEPTH_BITS-1:0]  depth_ff;
   logic [PHASE_BITS-1:0]  step_ff;
   logic [PHASE_BITS-1:0]  offset_ff;
   logic [MIX_BITS-1:0]    mix_ff;

   state_type            state_ff;
   logic                 voice_ff;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [RING_BITS-1:0] wi_ff;
   sample_type           dry_l_ff;
   sample_type           dry_r_ff;
   sample_type           sine_ff;
   logic [RING_BITS-1:0] i0_ff;
   logic [FRAC_BITS-1:0] frac_ff;
   sample_type           tap0_ff;
   sample_type           wet_ff;
   sample_type           out_l_ff;
   sample_type           out_r_ff;
   logic                 rsp_valid_ff;
   logic [DATA_BITS-1:0] rsp_data_ff;

   logic                           req_accept;
   logic                           rsp_free;
   logic [PHASE_BITS-1:0]          voice_phase;
   sample_type                     sine_w;
   logic [DATA_BITS-1:0]           ring_rdata;
   sample_type                     dry_w;
   sample_type                     tap_w;
   logic signed [SAMPLE_BITS:0]    tap_diff;
   logic [MIX_BITS-1:0]            mix_eff;
   logic signed [MAC_ACC_BITS-1:0] acc;
   logic signed [DLY_BITS-1:0]     delay_sum;
   logic [POS_BITS-1:0]            delay_lim;
   logic [POS_BITS-1:0]            pos;
   logic signed [SAMPLE_BITS:0]    mix_wide;
   sample_type                     mix_sat;
   mac_op_type                     mac_op;
   ring_req_type                   ring_req;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= CENTER_RESET;
         depth_ff  <= DEPTH_RESET;
         step_ff   <= STEP_RESET;
         offset_ff <= OFFSET_RESET;
         mix_ff    <= MIX_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CENTER_DELAY: center_ff <= csr_data[CENTER_BITS-1:0];
            CSR_DEPTH_DELAY:  depth_ff  <= csr_data[DEPTH_BITS-1:0];
            CSR_LFO_STEP:     step_ff   <= csr_data;
            CSR_RIGHT_OFFSET: offset_ff <= csr_data;
            CSR_MIX_AMOUNT:   mix_ff    <= csr_data[MIX_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign voice_phase = phase_ff + (voice_ff ? offset_ff : '0);
   assign mix_eff     = (mix_ff > MIX_FULL) ? MIX_FULL : mix_ff;
   assign dry_w       = voice_ff ? dry_r_ff : dry_l_ff;
   assign tap_w       = voice_ff ? $signed(ring_rdata[DATA_BITS-1 -: SAMPLE_BITS])
                                 : $signed(ring_rdata[SAMPLE_BITS-1:0]);
   assign tap_diff    = $signed({tap_w[SAMPLE_BITS-1], tap_w}) -
                        $signed({tap0_ff[SAMPLE_BITS-1], tap0_ff});

   scd_sine u_sine (
      .phase (voice_phase),
      .sine  (sine_w)
   );

   // delay in 1/256 samples, clamped to the ring, then the fractional read position
   assign delay_sum = $signed({{(DLY_BITS-CENTER_BITS){1'b0}}, center_ff}) +
                      $signed(acc[MIX_SHIFT +: DLY_BITS]);

   always_comb begin
      if (delay_sum[DLY_BITS-1]) begin
         delay_lim = '0;
      end else if (delay_sum > $signed({{(DLY_BITS-POS_BITS){1'b0}}, DELAY_MAX})) begin
         delay_lim = DELAY_MAX;
      end else begin
         delay_lim = delay_sum[POS_BITS-1:0];
      end
   end

   assign pos = {wi_ff, {FRAC_BITS{1'b0}}} - delay_lim;

   assign mix_wide = $signed(acc[MIX_SHIFT +: SAMPLE_BITS+1]);
   assign mix_sat  = (mix_wide[SAMPLE_BITS] != mix_wide[SAMPLE_BITS-1]) ?
                     (mix_wide[SAMPLE_BITS] ? sample_type'({1'b1, {(SAMPLE_BITS-1){1'b0}}})
                                            : sample_type'({1'b0, {(SAMPLE_BITS-1){1'b1}}}))
                     : mix_wide[SAMPLE_BITS-1:0];

   always_comb begin
      mac_op = '0;
      unique case (state_ff)
         S_DMUL: begin
            mac_op.issue = 1'b1;
            mac_op.load  = 1'b1;
            mac_op.bias  = '0;
            mac_op.op_a  = $signed({{(MAC_A_BITS-DEPTH_BITS){1'b0}}, depth_ff});
            mac_op.op_b  = $signed({{(MAC_B_BITS-SAMPLE_BITS){sine_ff[SAMPLE_BITS-1]}},
                                    sine_ff});
         end
         S_INT: begin
            mac_op.issue = 1'b1;
            mac_op.load  = 1'b1;
            mac_op.bias  = $signed({{(MAC_ACC_BITS-SAMPLE_BITS-FRAC_BITS)
                                     {tap0_ff[SAMPLE_BITS-1]}}, tap0_ff, INTERP_HALF});
            mac_op.op_a  = $signed({{(MAC_A_BITS-SAMPLE_BITS-1){tap_diff[SAMPLE_BITS]}},
                                    tap_diff});
            mac_op.op_b  = $signed({{(MAC_B_BITS-FRAC_BITS){1'b0}}, frac_ff});
         end
         S_MIX0: begin
            mac_op.issue = 1'b1;
            mac_op.load  = 1'b1;
            mac_op.bias  = MIX_ROUND;
            mac_op.op_a  = $signed({{(MAC_A_BITS-SAMPLE_BITS){dry_w[SAMPLE_BITS-1]}}, dry_w});
            mac_op.op_b  = $signed({1'b0, MIX_FULL} - {1'b0, mix_eff});
         end
         S_MIX1: begin
            mac_op.issue = 1'b1;
            mac_op.load  = 1'b0;
            mac_op.bias  = '0;
            mac_op.op_a  = $signed({{(MAC_A_BITS-SAMPLE_BITS){wet_ff[SAMPLE_BITS-1]}},
                                    wet_ff});
            mac_op.op_b  = $signed({1'b0, mix_eff});
         end
         default: ;
      endcase
   end

   scd_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mac_op),
      .acc   (acc)
   );

   always_comb begin
      ring_req = '0;
      unique case (state_ff)
         S_WRITE: begin
            ring_req.we    = 1'b1;
            ring_req.addr  = wi_ff;
            ring_req.wdata = {dry_r_ff, dry_l_ff};
         end
         S_RD0: begin
            ring_req.re   = 1'b1;
            ring_req.addr = i0_ff;
         end
         S_RD1: begin
            ring_req.re   = 1'b1;
            ring_req.addr = i0_ff + 1'b1;
         end
         default: ;
      endcase
   end

   scd_ring u_ring (
      .clock (clock),
      .reset (reset),
      .req   (ring_req),
      .rdata (ring_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         voice_ff     <= 1'b0;
         phase_ff     <= '0;
         wi_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_tready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  dry_l_ff <= $signed(req_tdata[SAMPLE_BITS-1:0]);
                  dry_r_ff <= $signed(req_tdata[DATA_BITS-1 -: SAMPLE_BITS]);
                  phase_ff <= phase_ff + step_ff;
                  voice_ff <= 1'b0;
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: state_ff <= S_SINE;
            S_SINE: begin
               sine_ff  <= sine_w;
               state_ff <= S_DMUL;
            end
            S_DMUL:  state_ff <= S_DWAIT;
            S_DWAIT: state_ff <= S_DPOS;
            S_DPOS: begin
               i0_ff    <= pos[POS_BITS-1 -: RING_BITS];
               frac_ff  <= pos[FRAC_BITS-1:0];
               state_ff <= S_RD0;
            end
            S_RD0: state_ff <= S_RD1;
            S_RD1: begin
               tap0_ff  <= tap_w;
               state_ff <= S_INT;
            end
            S_INT:   state_ff <= S_IWAIT;
            S_IWAIT: state_ff <= S_MIX0;
            S_MIX0: begin
               wet_ff   <= $signed(acc[FRAC_BITS +: SAMPLE_BITS]);
               state_ff <= S_MIX1;
            end
            S_MIX1:  state_ff <= S_MWAIT1;
            S_MWAIT1: state_ff <= S_MWAIT2;
            S_MWAIT2: begin
               if (voice_ff) begin
                  out_r_ff <= mix_sat;
                  state_ff <= S_DONE;
               end else begin
                  out_l_ff <= mix_sat;
                  voice_ff <= 1'b1;
                  state_ff <= S_SINE;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_data_ff  <= {out_r_ff, out_l_ff};
                  rsp_valid_ff <= 1'b1;
                  wi_ff        <= wi_ff + 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== hw/rtl/scd_sine.sv =====
`timescale 1ns / 1ps

module scd_sine (
   input  logic [scd_pkg::PHASE_BITS-1:0] phase,
   output scd_pkg::sample_type            sine
);
   import scd_pkg::*;

   localparam sine_table_type SINE_TABLE = build_sine_table();

   logic [SINE_BITS-1:0]   rom_index;
   logic [1:0]             quad;
   logic [QTR_BITS-1:0]    qtr_pos;
   logic [QTR_BITS:0]      tbl_index;
   logic [SAMPLE_BITS-1:0] mag;

   assign rom_index = phase[PHASE_BITS-1 -: SINE_BITS];
   assign quad      = rom_index[SINE_BITS-1 -: 2];
   assign qtr_pos   = rom_index[QTR_BITS-1:0];

   // mirror the odd quarters
   assign tbl_index = quad[0] ? (QTR_BITS+1)'(QTR_ENTRIES - 1) - {1'b0, qtr_pos}
                              : {1'b0, qtr_pos};
   assign mag       = SINE_TABLE[tbl_index];
   assign sine      = quad[1] ? -$signed(mag) : $signed(mag);

endmodule

// ===== hw/rtl/scd_mac.sv =====
`timescale 1ns / 1ps

module scd_mac (
   input  logic                                    clock,
   input  logic                                    reset,
   input  scd_pkg::mac_op_type                     op,
   output logic signed [scd_pkg::MAC_ACC_BITS-1:0] acc
);
   import scd_pkg::*;

   logic                           pend_ff;
   logic                           load_ff;
   logic signed [MAC_ACC_BITS-1:0] bias_ff;
   logic signed [MAC_P_BITS-1:0]   prod_ff;
   logic signed [MAC_ACC_BITS-1:0] acc_ff;
   logic signed [MAC_ACC_BITS-1:0] acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= op.issue;
      end
   end

   always_ff @(posedge clock) begin
      load_ff <= op.load;
      bias_ff <= $signed(op.bias);
      prod_ff <= $signed(op.op_a) * $signed(op.op_b);
   end

   assign acc_in = (load_ff ? bias_ff : acc_ff) +
                   $signed({{(MAC_ACC_BITS-MAC_P_BITS){prod_ff[MAC_P_BITS-1]}}, prod_ff});

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ===== hw/rtl/scd_ring.sv =====
`timescale 1ns / 1ps

module scd_ring (
   input  logic                          clock,
   input  logic                          reset,
   input  scd_pkg::ring_req_type         req,
   output logic [scd_pkg::DATA_BITS-1:0] rdata
);
   import scd_pkg::*;

   logic [DATA_BITS-1:0] mem [RING_DEPTH];
   logic [DATA_BITS-1:0] q_ff;
   logic                 hit_ff;
   logic [RING_BITS:0]   fill_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.addr] <= req.wdata;
      end
      if (req.re) begin
         q_ff <= mem[req.addr];
      end
   end

   // entries are written in address order from zero; unwritten ones read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         hit_ff  <= 1'b0;
      end else begin
         if (req.we && (fill_ff != (RING_BITS+1)'(RING_DEPTH))) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (req.re) begin
            hit_ff <= ({1'b0, req.addr} < fill_ff);
         end
      end
   end

   assign rdata = hit_ff ? q_ff : '0;

endmodule

// ===== hw/rtl/scd_checker.sv =====
`timescale 1ns / 1ps

module scd_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [scd_pkg::DATA_BITS-1:0] rsp_tdata,
   input logic csr_ready
);
   import scd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in work");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready && csr_ready)
      else $error("block not idle after reset");

   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without an item in work");

endmodule

bind stereo_chorus_delay_unit scd_checker u_scd_checker (.*);
